FILE: rtl/bkie_pkg.sv
package bkie_pkg;

    // A 64-bit word holds this many bases at two bits each.
    localparam int unsigned WORD_BASES = 32;

    // ASCII codes the encoder compares against.
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_C       = 8'h43;
    localparam logic [7:0] CHAR_G       = 8'h47;
    localparam logic [7:0] CHAR_T       = 8'h54;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Configuration register map.
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LENGTH     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CONVERSION_MODE = 1'b1;

    localparam logic [CFG_DATA_W-1:0] READ_LENGTH_RESET     = 7'd32;
    localparam logic                  CONVERSION_MODE_RESET = 1'b0;

    typedef enum logic [1:0] {
        KIND_FWD_BS    = 2'd0,
        KIND_FWD_PLAIN = 2'd1,
        KIND_RC_BS     = 2'd2,
        KIND_RC_PLAIN  = 2'd3
    } code_kind_t;

    typedef enum logic [1:0] {
        NUC_A = 2'd0,
        NUC_C = 2'd1,
        NUC_G = 2'd2,
        NUC_T = 2'd3
    } nuc_t;

    typedef struct packed {
        logic [7:0] base_char;
        logic       reverse_strand;
    } in_item_t;

    typedef struct packed {
        logic [63:0] first_word;
        logic [63:0] second_word;
        logic        invalid;
    } out_item_t;

    // Result of decoding one base: a two-bit code, or a flag for a non-ACGT base.
    typedef struct packed {
        logic       bad;
        logic [1:0] code;
    } base_code_t;

    function automatic logic [1:0] kind_code(code_kind_t kind, nuc_t nuc);
        logic [1:0] code;
        code = 2'd0;
        unique case (kind)
            KIND_FWD_BS: begin
                // C reads as T.
                code = (nuc == NUC_C) ? 2'd3 : nuc;
            end
            KIND_FWD_PLAIN: begin
                code = nuc;
            end
            KIND_RC_BS: begin
                // Complement, and G reads as A before complementing.
                code = (nuc == NUC_G) ? 2'd3 : ~nuc;
            end
            KIND_RC_PLAIN: begin
                code = ~nuc;
            end
            default: begin
                code = 2'd0;
            end
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/bkie_base_decode.sv
module bkie_base_decode
    import bkie_pkg::*;
(
    input  logic [7:0]  base_char,
    input  code_kind_t  kind,
    output base_code_t  result
);

    logic [7:0] upper;
    nuc_t       nuc;
    logic       bad;

    always_comb begin
        if (base_char >= CHAR_LOWER_A && base_char <= CHAR_LOWER_Z) begin
            upper = base_char - CASE_OFFSET;
        end else begin
            upper = base_char;
        end
    end

    always_comb begin
        bad = 1'b0;
        nuc = NUC_A;
        case (upper)
            CHAR_A: nuc = NUC_A;
            CHAR_C: nuc = NUC_C;
            CHAR_G: nuc = NUC_G;
            CHAR_T: nuc = NUC_T;
            default: bad = 1'b1;
        endcase
    end

    assign result.bad  = bad;
    assign result.code = kind_code(kind, nuc);

endmodule

FILE: rtl/bisulfite_kmer_index_encoder_core.sv
// Bisulfite k-mer index encoder.
// The input channel (s_valid / s_ready / s_item) carries one read base per item,
// in read order; reverse_strand is sampled at the first base of each read.
// After read_length bases the block issues one result item on the m_ channel:
// two 64-bit words packed at two bits per base and an invalid flag.
// Each base updates the accumulators in the cycle it is accepted (in CpG mode a
// forward base is held and folded with its successor), so a base can be taken
// on every clock. A read's result appears in the cycle after its last base is
// accepted and sits in a single output register. s_ready is high whenever that
// register is empty or being drained, so a base is taken every cycle unless a
// finished result is stalled by m_ready low; then input waits until it is taken.
// The configuration port (cfg_wr_en, cfg_index, cfg_wdata) writes read_length
// (index 0) and conversion_mode (index 1); any write restarts the read in
// progress. Writes are expected only while the block is idle.
// Synchronous active-low reset clears the read in progress and the output,
// and sets read_length to 32 and conversion_mode to full conversion.
module bisulfite_kmer_index_encoder_core
    import bkie_pkg::*;
#(
    parameter int unsigned SEGMENT_BASES  = 32,
    parameter int unsigned MAX_READ_BASES = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int unsigned POS_W = $clog2(MAX_READ_BASES + 1);
    localparam int unsigned SH_W  = POS_W + 1;
    localparam logic [POS_W-1:0] SEG_LEN    = POS_W'(SEGMENT_BASES);
    localparam logic [POS_W-1:0] WORD_LEN   = POS_W'(WORD_BASES);
    localparam logic [POS_W-1:0] POS_ONE    = POS_W'(1);
    localparam logic [POS_W-1:0] LEN_RESET  = POS_W'(READ_LENGTH_RESET);
    localparam logic [CFG_DATA_W-1:0] MAX_LEN_CFG = CFG_DATA_W'(MAX_READ_BASES);

    logic [63:0]      first_acc_reg,  first_acc_next;
    logic [63:0]      second_acc_reg, second_acc_next;
    logic [POS_W-1:0] pos_reg,        pos_next;
    logic [7:0]       held_reg,       held_next;
    logic [7:0]       prev_reg;
    logic             strand_reg,     strand_next;
    logic             inv_reg,        inv_next;
    logic [POS_W-1:0] len_reg;
    logic             mode_reg;
    logic             m_valid_reg;
    out_item_t        m_item_reg;

    logic             accept;
    logic             read_done;
    logic [POS_W-1:0] pos;
    logic             fwd_last;
    logic             rc_last;
    logic [POS_W-1:0] fstart;
    logic [POS_W-1:0] rc_off;
    logic [SH_W-1:0]  rc_shift;
    logic [63:0]      ch_code64;
    logic [63:0]      held_code64;
    logic [63:0]      rc_add;
    logic [63:0]      fwd_acc;
    logic [63:0]      fwd_step;
    logic             fwd_to_first;
    logic             do_held;
    code_kind_t       ch_kind;
    code_kind_t       held_kind;
    base_code_t       ch_dec;
    base_code_t       held_dec;
    logic [CFG_DATA_W-1:0] len_clamped;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign pos         = pos_reg;
    assign strand_next = (pos == '0) ? s_item.reverse_strand : strand_reg;
    assign read_done   = (pos == len_reg - POS_ONE);
    assign fstart      = (len_reg > SEG_LEN) ? (len_reg - SEG_LEN) : '0;
    assign fwd_last    = (pos == SEG_LEN - POS_ONE) || read_done;
    assign rc_last     = (pos + POS_ONE == fstart) || read_done;
    assign fwd_to_first = (pos < SEG_LEN);
    assign do_held     = (pos != '0) && (pos != SEG_LEN);

    // Code kind for the incoming base.
    always_comb begin
        if (!strand_next) begin
            if (!mode_reg || !fwd_last) begin
                ch_kind = KIND_FWD_BS;
            end else begin
                ch_kind = KIND_FWD_PLAIN;
            end
        end else begin
            if (!mode_reg) begin
                ch_kind = KIND_RC_BS;
            end else if (rc_last) begin
                ch_kind = KIND_RC_PLAIN;
            end else if (s_item.base_char == CHAR_G && pos != '0 && prev_reg == CHAR_C) begin
                ch_kind = KIND_RC_PLAIN;
            end else begin
                ch_kind = KIND_RC_BS;
            end
        end
    end

    // In CpG mode a forward base that does not end its word is committed once its successor is known.
    assign held_kind = (held_reg == CHAR_C && s_item.base_char == CHAR_G) ?
                       KIND_FWD_PLAIN : KIND_FWD_BS;

    bkie_base_decode u_ch_decode (
        .base_char (s_item.base_char),
        .kind      (ch_kind),
        .result    (ch_dec)
    );

    bkie_base_decode u_held_decode (
        .base_char (held_reg),
        .kind      (held_kind),
        .result    (held_dec)
    );

    // A non-ACGT base contributes minus one times its weight.
    assign ch_code64   = ch_dec.bad   ? '1 : {62'd0, ch_dec.code};
    assign held_code64 = held_dec.bad ? '1 : {62'd0, held_dec.code};

    // Reverse strand: each base lands at a digit given by its offset in its word.
    assign rc_off   = (pos >= fstart) ? (pos - fstart) : pos;
    assign rc_shift = {rc_off, 1'b0};
    assign rc_add   = (rc_off < WORD_LEN) ? (ch_code64 << rc_shift) : '0;

    // Forward strand: shift the selected word and append.
    assign fwd_acc = fwd_to_first ? first_acc_reg : second_acc_reg;
    always_comb begin
        if (!mode_reg) begin
            fwd_step = (fwd_acc << 2) + ch_code64;
        end else begin
            fwd_step = fwd_acc;
            if (do_held) begin
                fwd_step = (fwd_step << 2) + held_code64;
            end
            if (fwd_last) begin
                fwd_step = (fwd_step << 2) + ch_code64;
            end
        end
    end

    always_comb begin
        first_acc_next  = first_acc_reg;
        second_acc_next = second_acc_reg;
        held_next       = held_reg;
        if (!strand_next) begin
            if (fwd_to_first) begin
                first_acc_next = fwd_step;
            end else begin
                second_acc_next = fwd_step;
            end
            if (mode_reg && !fwd_last) begin
                held_next = s_item.base_char;
            end
        end else begin
            if (pos >= fstart) begin
                first_acc_next = first_acc_reg + rc_add;
            end else begin
                second_acc_next = second_acc_reg + rc_add;
            end
        end
        inv_next = inv_reg || ch_dec.bad;
        pos_next = read_done ? '0 : (pos + POS_ONE);
    end

    always_comb begin
        len_clamped = cfg_wdata;
        if (cfg_wdata == '0) begin
            len_clamped = CFG_DATA_W'(1);
        end else if (cfg_wdata > MAX_LEN_CFG) begin
            len_clamped = MAX_LEN_CFG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_acc_reg  <= '0;
            second_acc_reg <= '0;
            pos_reg        <= '0;
            held_reg       <= '0;
            prev_reg       <= '0;
            strand_reg     <= 1'b0;
            inv_reg        <= 1'b0;
            len_reg        <= LEN_RESET;
            mode_reg       <= CONVERSION_MODE_RESET;
            m_valid_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_READ_LENGTH:     len_reg  <= POS_W'(len_clamped);
                REG_CONVERSION_MODE: mode_reg <= cfg_wdata[0];
                default: ;
            endcase
            first_acc_reg  <= '0;
            second_acc_reg <= '0;
            pos_reg        <= '0;
            held_reg       <= '0;
            prev_reg       <= '0;
            strand_reg     <= 1'b0;
            inv_reg        <= 1'b0;
        end else begin
            if (accept) begin
                pos_reg    <= pos_next;
                held_reg   <= held_next;
                prev_reg   <= s_item.base_char;
                strand_reg <= strand_next;
                if (read_done) begin
                    first_acc_reg  <= '0;
                    second_acc_reg <= '0;
                    inv_reg        <= 1'b0;
                end else begin
                    first_acc_reg  <= first_acc_next;
                    second_acc_reg <= second_acc_next;
                    inv_reg        <= inv_next;
                end
            end
            if (accept && read_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && read_done) begin
            m_item_reg.first_word  <= first_acc_next;
            m_item_reg.second_word <= second_acc_next;
            m_item_reg.invalid     <= inv_next;
        end
    end

endmodule

FILE: rtl/bkie_port_checker.sv
module bkie_port_checker
    import bkie_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // A result held back by the receiver stays put.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed or dropped while stalled");

    // Input is only blocked by a stalled result.
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input blocked while output is free");

    // Reset leaves the output empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

    // A new result only follows an accepted item.
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result appeared without an accepted item");

endmodule

bind bisulfite_kmer_index_encoder_core bkie_port_checker u_port_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

FILE: test/tb_bisulfite_kmer_index_encoder_core.sv
module tb_bisulfite_kmer_index_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bkie_pkg::*;

    localparam int unsigned RANDOM_BASES = 960;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned MAX_LEN      = 64;
    localparam int unsigned SWEEP_STEPS  = 10;

    // Two-bit digit per code kind (row) and nucleotide A, C, G, T (column).
    localparam logic [1:0] DIGIT_TABLE [4][4] = '{
        '{2'd0, 2'd3, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd3, 2'd2, 2'd3, 2'd0},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };

    localparam logic [CFG_DATA_W-1:0] SWEEP_LEN [SWEEP_STEPS] = '{
        7'd1, 7'd1, 7'd64, 7'd64, 7'd33, 7'd32, 7'd0, 7'd127, 7'd2, 7'd31
    };
    localparam logic SWEEP_MODE [SWEEP_STEPS] = '{
        1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
    };

    localparam logic [7:0] ACGT_MIX [6] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T, CHAR_C, CHAR_G};

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_EVERY_FIFTH,
        RX_LONG_HOLD
    } rx_style_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predicted block state.
    logic [63:0]           first_acc   = '0;
    logic [63:0]           second_acc  = '0;
    int unsigned           base_idx    = 0;
    logic [7:0]            held_ch     = '0;
    logic [7:0]            prior_ch    = '0;
    logic                  strand_rev  = 1'b0;
    logic                  saw_invalid = 1'b0;
    logic [CFG_DATA_W-1:0] len_reg     = READ_LENGTH_RESET;
    logic                  cpg_keep    = CONVERSION_MODE_RESET;

    out_item_t   pending_words[$];
    int unsigned bases_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned errors       = 0;
    int unsigned burst_left   = 0;
    int unsigned cycle_count  = 0;
    int unsigned rx_tick      = 0;
    rx_style_t   rx_style     = RX_ALWAYS;

    bisulfite_kmer_index_encoder_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic decode_nuc(input logic [7:0] ch, output nuc_t nuc);
        logic [7:0] up;
        up = ch;
        nuc = NUC_A;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            up = ch - CASE_OFFSET;
        end
        case (up)
            CHAR_A: nuc = NUC_A;
            CHAR_C: nuc = NUC_C;
            CHAR_G: nuc = NUC_G;
            CHAR_T: nuc = NUC_T;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // A base outside ACGT weighs in as minus one.
    function automatic logic [63:0] digit_for(code_kind_t kind, logic [7:0] ch);
        nuc_t nuc;
        if (!decode_nuc(ch, nuc)) begin
            return '1;
        end
        return {62'd0, DIGIT_TABLE[kind][nuc]};
    endfunction

    function automatic void fold_forward(int unsigned at, logic [63:0] digit);
        if (at < WORD_BASES) begin
            first_acc = (first_acc << 2) + digit;
        end else begin
            second_acc = (second_acc << 2) + digit;
        end
    endfunction

    function automatic void clear_read();
        first_acc   = '0;
        second_acc  = '0;
        base_idx    = 0;
        held_ch     = '0;
        prior_ch    = '0;
        strand_rev  = 1'b0;
        saw_invalid = 1'b0;
    endfunction

    function automatic void encode_base(input in_item_t it);
        int unsigned len_eff;
        int unsigned p;
        int unsigned fstart;
        int unsigned off;
        logic [7:0]  ch;
        logic        last;
        code_kind_t  kind;
        logic [63:0] digit;
        nuc_t        nuc;
        out_item_t   res;
        ch = it.base_char;
        len_eff = (len_reg == 0) ? 1 : ((len_reg > MAX_LEN) ? MAX_LEN : len_reg);
        p = base_idx;
        if (p >= len_eff) begin
            p = 0;
        end
        if (p == 0) begin
            strand_rev = it.reverse_strand;
        end
        if (!decode_nuc(ch, nuc)) begin
            saw_invalid = 1'b1;
        end
        if (!strand_rev) begin
            last = (p == WORD_BASES - 1) || (p == len_eff - 1);
            if (!cpg_keep) begin
                fold_forward(p, digit_for(KIND_FWD_BS, ch));
            end else begin
                // The held base is settled once its successor is known.
                if (p != 0 && p != WORD_BASES) begin
                    kind = (held_ch == CHAR_C && ch == CHAR_G) ? KIND_FWD_PLAIN : KIND_FWD_BS;
                    fold_forward(p - 1, digit_for(kind, held_ch));
                end
                if (last) begin
                    fold_forward(p, digit_for(KIND_FWD_PLAIN, ch));
                end else begin
                    held_ch = ch;
                end
            end
        end else begin
            fstart = (len_eff > WORD_BASES) ? len_eff - WORD_BASES : 0;
            last = (p + 1 == fstart) || (p == len_eff - 1);
            if (!cpg_keep) begin
                kind = KIND_RC_BS;
            end else if (last) begin
                kind = KIND_RC_PLAIN;
            end else if (ch == CHAR_G && p > 0 && prior_ch == CHAR_C) begin
                kind = KIND_RC_PLAIN;
            end else begin
                kind = KIND_RC_BS;
            end
            digit = digit_for(kind, ch);
            off = (p >= fstart) ? p - fstart : p;
            digit = (off < WORD_BASES) ? (digit << (2 * off)) : '0;
            if (p >= fstart) begin
                first_acc = first_acc + digit;
            end else begin
                second_acc = second_acc + digit;
            end
        end
        prior_ch = ch;
        if (p == len_eff - 1) begin
            res.first_word  = first_acc;
            res.second_word = second_acc;
            res.invalid     = saw_invalid;
            pending_words.push_back(res);
            first_acc   = '0;
            second_acc  = '0;
            saw_invalid = 1'b0;
            base_idx    = 0;
        end else begin
            base_idx = p + 1;
        end
    endfunction

    function automatic logic [7:0] rand_base(logic clean);
        logic [7:0] pick;
        pick = ACGT_MIX[$urandom_range(0, 5)];
        case ($urandom_range(0, 9))
            0: return clean ? pick : 8'($urandom_range(0, 255));
            1, 2: return pick + CASE_OFFSET;
            default: return pick;
        endcase
    endfunction

    task automatic send_base(input in_item_t it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        bases_sent++;
        encode_base(it);
    endtask

    task automatic send_read(input string bases, input logic rev);
        in_item_t it;
        for (int i = 0; i < bases.len(); i++) begin
            it.base_char      = bases[i];
            it.reverse_strand = rev;
            send_base(it);
        end
    endtask

    // Only the first base's strand bit matters; the others are flipped now and then.
    task automatic send_random_read(input int unsigned n, input logic rev, input logic clean);
        in_item_t it;
        for (int unsigned b = 0; b < n; b++) begin
            it.base_char      = rand_base(clean);
            it.reverse_strand = (b == 0 || $urandom_range(0, 3) != 0) ? rev : !rev;
            send_base(it);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_READ_LENGTH) begin
            len_reg = data;
        end else begin
            cpg_keep = data[0];
        end
        clear_read();
    endtask

    // Unused upper bits of the mode write are randomized; only bit 0 counts.
    task automatic configure(input logic [CFG_DATA_W-1:0] len, input logic mode);
        logic [CFG_DATA_W-2:0] pad;
        pad = (CFG_DATA_W-1)'($urandom_range(0, 63));
        if ($urandom_range(0, 1) == 0) begin
            write_register(REG_READ_LENGTH, len);
            write_register(REG_CONVERSION_MODE, {pad, mode});
        end else begin
            write_register(REG_CONVERSION_MODE, {pad, mode});
            write_register(REG_READ_LENGTH, len);
        end
    endtask

    task automatic test_single_base_reads();
        configure(7'd1, 1'b0);
        send_base('{base_char: 8'h00, reverse_strand: 1'b0});
        send_base('{base_char: 8'hFF, reverse_strand: 1'b1});
        send_read("a", 1'b0);
        send_read("t", 1'b1);
        configure(7'd1, 1'b1);
        send_read("C", 1'b0);
        send_read("G", 1'b1);
    endtask

    task automatic test_cpg_context();
        configure(7'd4, 1'b1);
        send_read("CGCG", 1'b0);
        // The reverse read that follows starts with G right after a C.
        send_read("ACGC", 1'b0);
        send_read("GACG", 1'b1);
    endtask

    task automatic test_length_clamp();
        configure(7'd0, 1'b0);
        send_read("T", 1'b0);
        send_read("G", 1'b1);
    endtask

    task automatic test_restart_on_write();
        configure(7'd5, 1'b1);
        send_read("CC", 1'b0);
        configure(7'd5, 1'b0);
        send_read("GATTC", 1'b1);
    endtask

    task automatic test_random_reads();
        int unsigned start;
        int unsigned phase_start;
        int unsigned phase;
        int unsigned budget;
        int unsigned eff;
        logic [CFG_DATA_W-1:0] len;
        logic mode;
        start = bases_sent;
        phase = 0;
        while (bases_sent - start < RANDOM_BASES) begin
            if (phase < SWEEP_STEPS) begin
                len  = SWEEP_LEN[phase];
                mode = SWEEP_MODE[phase];
            end else begin
                len  = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(1, MAX_LEN));
                mode = 1'($urandom_range(0, 1));
            end
            configure(len, mode);
            eff = (len == 0) ? 1 : ((len > MAX_LEN) ? MAX_LEN : len);
            budget = $urandom_range(60, 120);
            phase_start = bases_sent;
            while (bases_sent - phase_start < budget) begin
                send_random_read(eff, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 9) == 0) begin
                    wait_idle();
                end
            end
            // Leave a read unfinished so that the next write has to discard it.
            if (eff > 1 && $urandom_range(0, 2) == 0) begin
                send_random_read($urandom_range(1, eff - 1), 1'($urandom_range(0, 1)), 1'b0);
            end
            phase++;
        end
    endtask

    always @(posedge aclk) begin
        rx_tick++;
        if (rx_tick % 64 == 0) begin
            rx_style = rx_style_t'($urandom_range(0, 3));
        end
        case (rx_style)
            RX_ALWAYS:      m_ready <= 1'b1;
            RX_COIN:        m_ready <= 1'($urandom_range(0, 1));
            RX_EVERY_FIFTH: m_ready <= (rx_tick % 5) != 0;
            default:        m_ready <= rx_tick[3];
        endcase
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("result item arrived with no read pending");
                errors++;
            end else begin
                want = pending_words.pop_front();
                results_seen++;
                if (m_item.first_word !== want.first_word) begin
                    $error("first_word: expected %h, got %h", want.first_word, m_item.first_word);
                    errors++;
                end
                if (m_item.second_word !== want.second_word) begin
                    $error("second_word: expected %h, got %h",
                           want.second_word, m_item.second_word);
                    errors++;
                end
                if (m_item.invalid !== want.invalid) begin
                    $error("invalid: expected %b, got %b", want.invalid, m_item.invalid);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** bisulfite_kmer_index_encoder_core: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_base_reads();
        test_cpg_context();
        test_length_clamp();
        test_restart_on_write();
        test_random_reads();
        wait_idle();
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("** bisulfite_kmer_index_encoder_core: PASSED **");
        end else begin
            $display("** bisulfite_kmer_index_encoder_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bkie_pkg.sv
rtl/bkie_base_decode.sv
rtl/bisulfite_kmer_index_encoder_core.sv
rtl/bkie_port_checker.sv
test/tb_bisulfite_kmer_index_encoder_core.sv
